>>> sv/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg: shared types and codes for the pin script sequencer
// opcodes, function codes, action codes, status codes, config indices, the beat type and the sequencer states
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [3:0] OP_MODE   = 4'd0;
  localparam logic [3:0] OP_DRIVE  = 4'd1;
  localparam logic [3:0] OP_TOGGLE = 4'd2;
  localparam logic [3:0] OP_SLEEP  = 4'd3;
  localparam logic [3:0] OP_WAIT   = 4'd4;
  localparam logic [3:0] OP_BEEP   = 4'd5;
  localparam logic [3:0] OP_GOTO   = 4'd6;
  localparam logic [3:0] OP_IFGOTO = 4'd7;
  localparam logic [3:0] OP_END    = 4'd8;

  localparam logic [2:0] ACT_STATUS    = 3'd0;
  localparam logic [2:0] ACT_MODE      = 3'd1;
  localparam logic [2:0] ACT_DRIVE     = 3'd2;
  localparam logic [2:0] ACT_TONE_ON   = 3'd3;
  localparam logic [2:0] ACT_TONE_OFF  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_PIN = 2'd1;
  localparam logic [1:0] ST_BAD_CMD = 2'd2;

  localparam int unsigned CFG_PROGRAM_LENGTH = 0;
  localparam int unsigned CFG_SUPPORTED_PINS = 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLEEP,
    S_WAITCHK,
    S_FETCH,
    S_EXEC,
    S_EMIT,
    S_STATUS
  } seq_state_e;

  // one decoded result beat
  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  pin_code;
    logic        pin_value;
    logic [15:0] tone_value;
  } beat_t;

endpackage

>>> sv/gpio_script_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_script_sequencer_top: pin script sequencer
// load, start, stop and tick beats drive a small instruction engine
// ----------------------------------------------------------------------------
// load, start, stop: the status step follows the taken input beat and registers the status beat
// tick: sleep check, wait check, then a fetch and an execute step per instruction
//   (at most budget instructions, budget clamped to BUDGET_MAX), a final fetch
//   and status; a pending sleep or wait, or a blocking or ending op, exits early
// one input beat at a time; the next is taken once the status beat has left
// every result beat waits in the output register until taken; emitting steps stall
// reset clears all control state; the program store is not cleared
module gpio_script_sequencer_top
  import gss_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH = 64,
  parameter int unsigned BUDGET_MAX    = 32,
  parameter int unsigned PIN_COUNT     = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [5:0]  load_index_i,
  input  logic [3:0]  op_code_i,
  input  logic [15:0] arg_a_i,
  input  logic [15:0] arg_b_i,
  input  logic [15:0] arg_c_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [5:0]  step_budget_i,
  input  logic [PIN_COUNT-1:0] pin_levels_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [6:0]  pin_code_o,
  output logic        pin_value_o,
  output logic [15:0] tone_value_o,
  output logic [1:0]  status_o,
  output logic        running_o,
  output logic        last_item_o
);

  localparam int unsigned AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int unsigned PW = $clog2(PIN_COUNT);

  // configuration registers
  logic [6:0]           prog_len_q;
  logic [PIN_COUNT-1:0] supported_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q  <= '0;
      supported_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'(CFG_PROGRAM_LENGTH)) prog_len_q <= cfg_data_i[6:0];
      else supported_q <= PIN_COUNT'(cfg_data_i);
    end
  end

  // effective program length, clamped to the store depth
  logic [16:0] len_eff;
  assign len_eff = (32'(prog_len_q) > PROGRAM_DEPTH) ? 17'(PROGRAM_DEPTH)
                                                     : 17'(prog_len_q);

  // engine state
  seq_state_e state_q, state_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] sleep_q, sleep_d;
  logic        tone_q, tone_d;
  logic        wait_q, wait_d;
  logic [6:0]  wpin_q, wpin_d;
  logic [15:0] wlvl_q, wlvl_d;
  logic        run_q, run_d;
  logic [1:0]  stat_q, stat_d;
  logic [PIN_COUNT-1:0] latch_q, latch_d, dir_q, dir_d;
  // per-tick working copies
  logic [15:0] elap_q, elap_d;
  logic [5:0]  bud_q, bud_d;
  logic [PIN_COUNT-1:0] lvl_q, lvl_d;
  // output register
  logic        ov_q, ov_d;
  beat_t       ob_q, ob_d;
  logic        olast_q, olast_d;
  logic        ostall_pend;

  // program store
  logic        mem_we;
  logic [51:0] mem_rd;
  gss_prog_mem #(.DEPTH(PROGRAM_DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(load_index_i)),
    .wdata_i ({op_code_i, arg_a_i, arg_b_i, arg_c_i}),
    .raddr_i (AW'(pc_q)),
    .rdata_o (mem_rd)
  );

  logic        in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign mem_we = in_acc && (func_i == FUNC_LOAD) &&
                  (32'(load_index_i) < PROGRAM_DEPTH);

  logic [3:0]  i_op;
  logic [15:0] i_a, i_b, i_c;
  assign {i_op, i_a, i_b, i_c} = mem_rd;

  // shared pin decoder: executing instruction's pin or the wait pin
  logic [15:0] pu_code;
  logic        pu_ok, pu_lvl;
  logic [PW-1:0] pu_idx;
  assign pu_code = (state_q == S_WAITCHK) ? {9'd0, wpin_q} : i_a;
  gss_pin_unit #(.PIN_COUNT(PIN_COUNT), .PW(PW)) u_pin (
    .code_i      (pu_code),
    .supported_i (supported_q),
    .levels_i    (lvl_q),
    .ok_o        (pu_ok),
    .idx_o       (pu_idx),
    .level_o     (pu_lvl)
  );

  assign in_stall_o  = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign action_o    = ob_q.action;
  assign pin_code_o  = ob_q.pin_code;
  assign pin_value_o = ob_q.pin_value;
  assign tone_value_o = ob_q.tone_value;
  assign status_o    = stat_q;
  assign running_o   = run_q;
  assign last_item_o = olast_q;

  // output slot still held this cycle by a stalled beat
  assign ostall_pend = ov_q && out_stall_i;

  always_comb begin
    logic [PIN_COUNT-1:0] bit_m;
    logic cur;
    state_d = state_q;
    pc_d = pc_q; sleep_d = sleep_q; tone_d = tone_q; wait_d = wait_q;
    wpin_d = wpin_q; wlvl_d = wlvl_q; run_d = run_q; stat_d = stat_q;
    latch_d = latch_q; dir_d = dir_q;
    elap_d = elap_q; bud_d = bud_q; lvl_d = lvl_q;
    ov_d = ov_q && out_stall_i;
    ob_d = ob_q; olast_d = olast_q;
    bit_m = PIN_COUNT'(1) << pu_idx;
    cur = dir_q[pu_idx] ? latch_q[pu_idx] : lvl_q[pu_idx];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          elap_d = elapsed_ms_i;
          bud_d  = (32'(step_budget_i) > BUDGET_MAX) ? 6'(BUDGET_MAX) : step_budget_i;
          lvl_d  = pin_levels_i;
          state_d = S_STATUS;
          case (func_i)
            FUNC_START: begin
              pc_d = '0; sleep_d = '0; tone_d = 1'b0; wait_d = 1'b0;
              wpin_d = '0; wlvl_d = '0; stat_d = ST_OK; run_d = 1'b1;
            end
            FUNC_STOP: begin
              run_d = 1'b0; wait_d = 1'b0; sleep_d = '0;
            end
            FUNC_TICK: begin
              if (run_q) state_d = S_SLEEP;
            end
            default: ;
          endcase
        end
      end
      S_SLEEP: begin
        if (sleep_q == '0) begin
          state_d = S_WAITCHK;
        end else if (elap_q < sleep_q) begin
          sleep_d = sleep_q - elap_q;
          state_d = S_STATUS;
        end else if (!ostall_pend) begin
          elap_d = elap_q - sleep_q;
          sleep_d = '0;
          state_d = S_WAITCHK;
          if (tone_q) begin
            tone_d = 1'b0;
            ov_d = 1'b1; olast_d = 1'b0;
            ob_d = '{action: ACT_TONE_OFF, pin_code: '0, pin_value: 1'b0,
                     tone_value: '0};
          end
        end
      end
      S_WAITCHK: begin
        if (wait_q && ({15'd0, pu_lvl} != wlvl_q)) begin
          state_d = S_STATUS;
        end else begin
          wait_d = 1'b0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        // memory read of pc_q lands next cycle
        if ({1'b0, pc_q} < len_eff && bud_q != '0) begin
          state_d = S_EXEC;
        end else if (!ostall_pend) begin
          // running and status must hold while an earlier beat waits
          if ({1'b0, pc_q} >= len_eff) begin
            run_d = 1'b0; stat_d = ST_OK;
          end
          state_d = S_STATUS;
        end
      end
      S_EXEC: begin
        if (!ostall_pend) begin
          bud_d = bud_q - 6'd1;
          state_d = S_FETCH;
          case (i_op)
            OP_MODE, OP_DRIVE, OP_TOGGLE: begin
              if (!pu_ok) begin
                run_d = 1'b0; stat_d = ST_BAD_PIN; state_d = S_STATUS;
              end else begin
                ov_d = 1'b1; olast_d = 1'b0;
                ob_d.pin_code = i_a[6:0];
                ob_d.tone_value = '0;
                pc_d = pc_q + 16'd1;
                if (i_op == OP_MODE) begin
                  ob_d.action = ACT_MODE;
                  ob_d.pin_value = (i_b != '0);
                  dir_d = (i_b != '0) ? (dir_q | bit_m) : (dir_q & ~bit_m);
                end else if (i_op == OP_DRIVE) begin
                  ob_d.action = ACT_DRIVE;
                  ob_d.pin_value = (i_b != '0);
                  latch_d = (i_b != '0) ? (latch_q | bit_m) : (latch_q & ~bit_m);
                end else begin
                  ob_d.action = ACT_DRIVE;
                  ob_d.pin_value = !cur;
                  latch_d = cur ? (latch_q & ~bit_m) : (latch_q | bit_m);
                end
              end
            end
            OP_SLEEP: begin
              pc_d = pc_q + 16'd1;
              if (i_c > elap_q) begin
                sleep_d = i_c - elap_q;
                state_d = S_STATUS;
              end else begin
                elap_d = elap_q - i_c;
              end
            end
            OP_WAIT: begin
              if (!pu_ok) begin
                run_d = 1'b0; stat_d = ST_BAD_PIN; state_d = S_STATUS;
              end else begin
                pc_d = pc_q + 16'd1;
                if ({15'd0, pu_lvl} != i_b) begin
                  wpin_d = i_a[6:0]; wlvl_d = i_b; wait_d = 1'b1;
                  state_d = S_STATUS;
                end
              end
            end
            OP_BEEP: begin
              ov_d = 1'b1; olast_d = 1'b0;
              ob_d = '{action: ACT_TONE_ON, pin_code: '0, pin_value: 1'b0,
                       tone_value: i_a};
              tone_d = 1'b1; sleep_d = i_b;
              pc_d = pc_q + 16'd1;
              state_d = S_STATUS;
            end
            OP_GOTO: pc_d = i_c;
            OP_IFGOTO: pc_d = ({15'd0, pu_lvl} == i_b) ? i_c : pc_q + 16'd1;
            OP_END: begin
              run_d = 1'b0; stat_d = ST_OK; state_d = S_STATUS;
            end
            default: begin
              run_d = 1'b0; stat_d = ST_BAD_CMD; state_d = S_STATUS;
            end
          endcase
        end
      end
      S_STATUS: begin
        if (!ostall_pend) begin
          ov_d = 1'b1; olast_d = 1'b1;
          ob_d = '{action: ACT_STATUS, pin_code: '0, pin_value: 1'b0,
                   tone_value: '0};
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold off new beats until the status beat leaves
        if (!ov_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // status and running ride with the beat; they are sampled from live state
  // which cannot change while a beat waits, since the engine stalls on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0; sleep_q <= '0; tone_q <= 1'b0; wait_q <= 1'b0;
      wpin_q <= '0; wlvl_q <= '0; run_q <= 1'b0; stat_q <= ST_OK;
      latch_q <= '0; dir_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; sleep_q <= sleep_d; tone_q <= tone_d; wait_q <= wait_d;
      wpin_q <= wpin_d; wlvl_q <= wlvl_d; run_q <= run_d; stat_q <= stat_d;
      latch_q <= latch_d; dir_q <= dir_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elap_q <= elap_d; bud_q <= bud_d; lvl_q <= lvl_d;
    ob_q <= ob_d; olast_q <= olast_d;
  end

endmodule

>>> sv/gss_prog_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_prog_mem: program store
// one write port, one registered read port
// ----------------------------------------------------------------------------
module gss_prog_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [51:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [51:0]   rdata_o
);

  logic [51:0] mem [DEPTH];
  logic [51:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gss_pin_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pin_unit: pin decode
// maps a pin code to a bit index, reads its level and checks support
// ----------------------------------------------------------------------------
module gss_pin_unit #(
  parameter int unsigned PIN_COUNT = 48,
  parameter int unsigned PW        = 6
) (
  input  logic [15:0]          code_i,
  input  logic [PIN_COUNT-1:0] supported_i,
  input  logic [PIN_COUNT-1:0] levels_i,
  output logic                 ok_o,
  output logic [PW-1:0]        idx_o,
  output logic                 level_o
);

  logic [6:0] idx_full;
  logic       pin_valid;

  always_comb begin
    idx_full  = {1'b0, code_i[6:5], code_i[3:0]};
    pin_valid = (code_i[15:7] == '0) && !code_i[4] && (32'(idx_full) < PIN_COUNT);
    idx_o     = PW'(idx_full);
    ok_o      = pin_valid && supported_i[idx_o];
    level_o   = pin_valid && levels_i[idx_o];
  end

endmodule
